// ===== hw/rtl/vna_pkg.sv =====
package vna_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int POS_W            = 24;
   localparam int ACC_W            = 56;
   localparam int NORM_W           = 16;
   localparam int VIDX_W           = 10;
   localparam int IVAL_W           = 32;

   localparam logic [IVAL_W-1:0] RESTART_SHORT = 32'h0000_FFFF;
   localparam logic [IVAL_W-1:0] RESTART_LONG  = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_INDEX = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TRI_RD,
      ST_DIFF,
      ST_CROSS,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_MAG,
      ST_SHIFT,
      ST_SQ,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_END,
      ST_EMIT
   } state_type;

endpackage

// ===== hw/rtl/vna_ram.sv =====
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hw/rtl/vertex_normal_accumulator_unit.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_type, req_vertex_index, req_pos_x/y/z,
//                                             req_index_value
// rsp       out        rsp_valid/rsp_stall   rsp_status, rsp_normal_vertex, rsp_normal_x/y/z
//
// A completed triangle takes three position reads, six products on the shared multiplier
// and three read-modify-writes. A read may take a 1-bit-per-cycle scaling shift, three
// squares, a 32-step root and three 17-step divisions. Reset and a clear request sweep
// the accumulator RAM with req stalled. A pending result waits in the output register
// while rsp_stall is high.
module vertex_normal_accumulator_unit
   import vna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic [VIDX_W-1:0]        req_vertex_index,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic [IVAL_W-1:0]        req_index_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_status,
   output logic [VIDX_W-1:0]        rsp_normal_vertex,
   output logic signed [NORM_W-1:0] rsp_normal_x,
   output logic signed [NORM_W-1:0] rsp_normal_y,
   output logic signed [NORM_W-1:0] rsp_normal_z
);

   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int PW   = 3 * POS_W;
   localparam int VW   = 3 * ACC_W;
   localparam int DW   = POS_W + 1;

   state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]    gcount_ff, gcount_in;
   logic [AW-1:0] first_ff, first_in, second_ff, second_in, third_ff, third_in;
   logic [PW-1:0] corner_ff [3];
   logic [PW-1:0] corner_in [3];
   logic signed [DW-1:0] diff_ff [6];
   logic signed [DW-1:0] diff_in [6];
   logic signed [63:0]   prod_ff, prod_in;
   logic [ACC_W-1:0] cross_ff [3];
   logic [ACC_W-1:0] cross_in [3];
   logic [ACC_W-1:0] mag_ff [3];
   logic [ACC_W-1:0] mag_in [3];
   logic [2:0]    neg_ff, neg_in;
   logic [62:0]   sum_ff, sum_in;
   logic [63:0]   root_ff, root_in;
   logic [62:0]   bit_ff, bit_in;
   logic [1:0]    comp_ff, comp_in;
   logic [31:0]   rem_ff, rem_in;
   logic [16:0]   numlo_ff, numlo_in, quo_ff, quo_in;
   logic          res_status_ff, res_status_in;
   logic [VIDX_W-1:0] res_vertex_ff, res_vertex_in;
   logic [NORM_W-1:0] res_n_ff [3];
   logic [NORM_W-1:0] res_n_in [3];
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_status_ff;
   logic [VIDX_W-1:0] rsp_vertex_ff;
   logic [NORM_W-1:0] rsp_n_ff [3];
   logic          rsp_load;

   logic signed [31:0] mul_a, mul_b;
   logic          pos_we, acc_we;
   logic [AW-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
   logic [PW-1:0] pos_wdata, pos_rdata;
   logic [VW-1:0] acc_wdata, acc_rdata;
   logic          req_accept, rsp_free, restart, idx_in_range, vi_in_range;
   logic [AW-1:0] corner_addr;
   logic [ACC_W-1:0] vec [3];
   logic [ACC_W-1:0] orv;
   logic [63:0]   sq_t;
   logic [45:0]   num;
   logic [32:0]   div_t;
   logic          div_ge;
   logic [16:0]   qsat;

   vna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata)
   );

   vna_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_acc_ram (
      .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
      .raddr(acc_raddr), .rdata(acc_rdata)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign restart      = (req_index_value == RESTART_SHORT) || (req_index_value == RESTART_LONG);
   assign idx_in_range = req_index_value < IVAL_W'(MAX_VERTICES);
   assign vi_in_range  = IVAL_W'(req_vertex_index) < IVAL_W'(MAX_VERTICES);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    corner_addr = first_ff;
         2'd1:    corner_addr = second_ff;
         default: corner_addr = third_ff;
      endcase
   end

   // shared multiplier: cross-product terms, then squares of the scaled magnitudes
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_CROSS) begin
         case (cnt_ff[2:0])
            3'd0:    begin mul_a = 32'(diff_ff[1]); mul_b = 32'(diff_ff[5]); end
            3'd1:    begin mul_a = 32'(diff_ff[2]); mul_b = 32'(diff_ff[4]); end
            3'd2:    begin mul_a = 32'(diff_ff[2]); mul_b = 32'(diff_ff[3]); end
            3'd3:    begin mul_a = 32'(diff_ff[0]); mul_b = 32'(diff_ff[5]); end
            3'd4:    begin mul_a = 32'(diff_ff[0]); mul_b = 32'(diff_ff[4]); end
            3'd5:    begin mul_a = 32'(diff_ff[1]); mul_b = 32'(diff_ff[3]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_SQ && cnt_ff < 6'd3) begin
         mul_a = {2'b00, mag_ff[cnt_ff[1:0]][29:0]};
         mul_b = {2'b00, mag_ff[cnt_ff[1:0]][29:0]};
      end
   end
   assign prod_in = mul_a * mul_b;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec[i] = acc_rdata[VW-1-ACC_W*i -: ACC_W];
      end
      orv    = mag_ff[0] | mag_ff[1] | mag_ff[2];
      sq_t   = root_ff + {1'b0, bit_ff};
      num    = {mag_ff[comp_ff][29:0], 15'd0} + 46'(root_ff[31:1]);
      div_t  = {rem_ff, numlo_ff[16]};
      div_ge = div_t >= {1'b0, root_ff[31:0]};
      if (neg_ff[comp_ff]) begin
         qsat = (quo_ff > 17'd32768) ? 17'd32768 : quo_ff;
         qsat = 17'd0 - qsat;
      end else begin
         qsat = (quo_ff > 17'd32767) ? 17'd32767 : quo_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_addr_in   = clr_addr_ff;
      gcount_in     = gcount_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      third_in      = third_ff;
      corner_in     = corner_ff;
      diff_in       = diff_ff;
      cross_in      = cross_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      sum_in        = sum_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      comp_in       = comp_ff;
      rem_in        = rem_ff;
      numlo_in      = numlo_ff;
      quo_in        = quo_ff;
      res_status_in = res_status_ff;
      res_vertex_in = res_vertex_ff;
      res_n_in      = res_n_ff;
      rsp_load      = 1'b0;
      pos_we        = 1'b0;
      pos_waddr     = AW'(req_vertex_index);
      pos_wdata     = {req_pos_x, req_pos_y, req_pos_z};
      pos_raddr     = corner_addr;
      acc_we        = 1'b0;
      acc_waddr     = corner_addr;
      acc_wdata     = '0;
      acc_raddr     = corner_addr;

      case (state_ff)
         ST_CLEAR: begin
            acc_we    = 1'b1;
            acc_waddr = clr_addr_ff;
            if (clr_addr_ff == AW'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            acc_raddr = AW'(req_vertex_index);
            if (req_accept) begin
               case (req_type)
                  REQ_LOAD: begin
                     pos_we = vi_in_range;
                  end
                  REQ_INDEX: begin
                     if (restart && gcount_ff == 2'd0) begin
                        gcount_in = 2'd0;
                     end else if (restart || !idx_in_range) begin
                        gcount_in     = 2'd0;
                        res_status_in = 1'b1;
                        res_vertex_in = '0;
                        res_n_in      = '{default: '0};
                        state_in      = ST_EMIT;
                     end else if (gcount_ff == 2'd0) begin
                        first_in  = AW'(req_index_value);
                        gcount_in = 2'd1;
                     end else if (gcount_ff == 2'd1) begin
                        second_in = AW'(req_index_value);
                        gcount_in = 2'd2;
                     end else begin
                        third_in  = AW'(req_index_value);
                        gcount_in = 2'd0;
                        cnt_in    = '0;
                        state_in  = ST_TRI_RD;
                     end
                  end
                  REQ_READ: begin
                     res_status_in = 1'b0;
                     res_vertex_in = req_vertex_index;
                     res_n_in      = '{default: '0};
                     state_in      = vi_in_range ? ST_MAG : ST_EMIT;
                  end
                  REQ_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TRI_RD: begin
            // position RAM read is registered: data for the read issued at one step lands at the next step
            if (cnt_ff != 6'd0) begin
               corner_in[cnt_ff[1:0] - 2'd1] = pos_rdata;
            end
            if (cnt_ff == 6'd3) begin
               state_in = ST_DIFF;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               diff_in[i]   = $signed({corner_ff[0][PW-1-POS_W*i], corner_ff[0][PW-1-POS_W*i -: POS_W]})
                            - $signed({corner_ff[1][PW-1-POS_W*i], corner_ff[1][PW-1-POS_W*i -: POS_W]});
               diff_in[3+i] = $signed({corner_ff[2][PW-1-POS_W*i], corner_ff[2][PW-1-POS_W*i -: POS_W]})
                            - $signed({corner_ff[1][PW-1-POS_W*i], corner_ff[1][PW-1-POS_W*i -: POS_W]});
            end
            cnt_in   = '0;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            case (cnt_ff[2:0])
               3'd1:    cross_in[0] = prod_ff[ACC_W-1:0];
               3'd2:    cross_in[0] = cross_ff[0] - prod_ff[ACC_W-1:0];
               3'd3:    cross_in[1] = prod_ff[ACC_W-1:0];
               3'd4:    cross_in[1] = cross_ff[1] - prod_ff[ACC_W-1:0];
               3'd5:    cross_in[2] = prod_ff[ACC_W-1:0];
               3'd6:    cross_in[2] = cross_ff[2] - prod_ff[ACC_W-1:0];
               default: cross_in    = cross_ff;
            endcase
            if (cnt_ff == 6'd6) begin
               cnt_in   = '0;
               state_in = ST_ACC_RD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ACC_RD: begin
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            acc_we = 1'b1;
            for (int i = 0; i < 3; i++) begin
               acc_wdata[VW-1-ACC_W*i -: ACC_W] = vec[i] + cross_ff[i];
            end
            if (cnt_ff == 6'd2) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_ACC_RD;
            end
         end
         ST_MAG: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = vec[i][ACC_W-1];
               mag_in[i] = vec[i][ACC_W-1] ? (ACC_W'(0) - vec[i]) : vec[i];
            end
            state_in = ((vec[0] | vec[1] | vec[2]) == '0) ? ST_EMIT : ST_SHIFT;
         end
         ST_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (orv[ACC_W-1:30] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!orv[29]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (cnt_ff != 6'd0) begin
               sum_in = sum_ff + prod_ff[62:0];
            end
            if (cnt_ff == 6'd3) begin
               cnt_in   = '0;
               root_in  = '0;
               bit_in   = {1'b1, 62'd0};
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if ({1'b0, sum_ff} >= sq_t) begin
               sum_in  = sum_ff - sq_t[62:0];
               root_in = (root_ff >> 1) + {1'b0, bit_ff};
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == 6'd31) begin
               comp_in  = '0;
               state_in = ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_INIT: begin
            rem_in   = {3'd0, num[45:17]};
            numlo_in = num[16:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = div_ge ? 32'(div_t - {1'b0, root_ff[31:0]}) : div_t[31:0];
            quo_in   = {quo_ff[15:0], div_ge};
            numlo_in = {numlo_ff[15:0], 1'b0};
            if (cnt_ff == 6'd16) begin
               state_in = ST_DIV_END;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV_END: begin
            res_n_in[comp_ff] = qsat[NORM_W-1:0];
            if (comp_ff == 2'd2) begin
               state_in = ST_EMIT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         gcount_ff    <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         gcount_ff    <= gcount_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      third_ff      <= third_in;
      corner_ff     <= corner_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      cross_ff      <= cross_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      sum_ff        <= sum_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      rem_ff        <= rem_in;
      numlo_ff      <= numlo_in;
      quo_ff        <= quo_in;
      res_status_ff <= res_status_in;
      res_vertex_ff <= res_vertex_in;
      res_n_ff      <= res_n_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_vertex_ff <= res_vertex_ff;
         rsp_n_ff      <= res_n_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_normal_vertex = rsp_vertex_ff;
   assign rsp_normal_x      = rsp_n_ff[0];
   assign rsp_normal_y      = rsp_n_ff[1];
   assign rsp_normal_z      = rsp_n_ff[2];

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import vna_pkg::*;

   localparam int NVERT      = 1024;
   localparam int CYCLE_CAP  = 1500000;
   localparam int TAIL_WAIT  = 300;

   typedef struct {
      req_code_type              kind;
      logic [VIDX_W-1:0]         vidx;
      logic signed [POS_W-1:0]   px;
      logic signed [POS_W-1:0]   py;
      logic signed [POS_W-1:0]   pz;
      logic [IVAL_W-1:0]         ival;
      bit                        drain;   // hold off until every result is back
   } req_item_type;

   typedef struct {
      logic                     status;
      logic [VIDX_W-1:0]        vertex;
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nz;
   } normal_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic [VIDX_W-1:0] req_vertex_index = '0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic [IVAL_W-1:0] req_index_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_status;
   logic [VIDX_W-1:0] rsp_normal_vertex;
   logic signed [NORM_W-1:0] rsp_normal_x;
   logic signed [NORM_W-1:0] rsp_normal_y;
   logic signed [NORM_W-1:0] rsp_normal_z;

   vertex_normal_accumulator_unit i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow state of the block
   logic signed [POS_W-1:0] pos_x_mem [NVERT];
   logic signed [POS_W-1:0] pos_y_mem [NVERT];
   logic signed [POS_W-1:0] pos_z_mem [NVERT];
   logic [ACC_W-1:0] sum_x [NVERT];
   logic [ACC_W-1:0] sum_y [NVERT];
   logic [ACC_W-1:0] sum_z [NVERT];
   int unsigned corner_a, corner_b, gathered;

   req_item_type   pending_reqs [$];
   normal_rsp_type pending_normals [$];
   int written_ids [$];
   bit is_written [NVERT];
   int accepted = 0;
   int errors = 0;
   int cycles = 0;
   int rx_hold = 0;
   bit hold_done = 0;
   bit stim_done = 0;

   function automatic longint unsigned root64(input longint unsigned s);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic normal_rsp_type unit_normal(input logic [VIDX_W-1:0] v);
      normal_rsp_type res;
      logic [ACC_W-1:0] a [3];
      longint unsigned mag [3];
      bit neg [3];
      longint unsigned top = 0, ssq = 0, len, q;
      logic [NORM_W-1:0] c [3];
      a[0] = sum_x[v]; a[1] = sum_y[v]; a[2] = sum_z[v];
      for (int k = 0; k < 3; k++) begin
         neg[k] = a[k][ACC_W-1];
         mag[k] = neg[k] ? 64'(ACC_W'(-a[k])) : 64'(a[k]);
         if (mag[k] > top) top = mag[k];
         c[k] = '0;
      end
      if (top != 0) begin
         while (top >= (64'd1 << 30)) begin
            top >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
         end
         while (top < (64'd1 << 29)) begin
            top <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
         end
         for (int k = 0; k < 3; k++) ssq += mag[k] * mag[k];
         len = root64(ssq);
         for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 15) + (len >> 1)) / len;
            if (neg[k]) begin
               if (q > 32768) q = 32768;
               c[k] = -q[15:0];
            end else begin
               if (q > 32767) q = 32767;
               c[k] = q[15:0];
            end
         end
      end
      res.status = 1'b0;
      res.vertex = v;
      res.nx = c[0]; res.ny = c[1]; res.nz = c[2];
      return res;
   endfunction

   function automatic void add_face(input int unsigned ia, ib, ic);
      longint d1x, d1y, d1z, d2x, d2y, d2z, cx, cy, cz;
      int unsigned corner [3];
      d1x = longint'(pos_x_mem[ia]) - longint'(pos_x_mem[ib]);
      d1y = longint'(pos_y_mem[ia]) - longint'(pos_y_mem[ib]);
      d1z = longint'(pos_z_mem[ia]) - longint'(pos_z_mem[ib]);
      d2x = longint'(pos_x_mem[ic]) - longint'(pos_x_mem[ib]);
      d2y = longint'(pos_y_mem[ic]) - longint'(pos_y_mem[ib]);
      d2z = longint'(pos_z_mem[ic]) - longint'(pos_z_mem[ib]);
      cx = d1y * d2z - d1z * d2y;
      cy = d1z * d2x - d1x * d2z;
      cz = d1x * d2y - d1y * d2x;
      corner[0] = ia; corner[1] = ib; corner[2] = ic;
      for (int k = 0; k < 3; k++) begin
         sum_x[corner[k]] = sum_x[corner[k]] + ACC_W'(cx);
         sum_y[corner[k]] = sum_y[corner[k]] + ACC_W'(cy);
         sum_z[corner[k]] = sum_z[corner[k]] + ACC_W'(cz);
      end
   endfunction

   function automatic void predict_normals(input req_item_type it);
      normal_rsp_type drop;
      bit restart;
      drop = '{1'b1, '0, '0, '0, '0};
      case (it.kind)
         REQ_LOAD: begin
            pos_x_mem[it.vidx] = it.px;
            pos_y_mem[it.vidx] = it.py;
            pos_z_mem[it.vidx] = it.pz;
         end
         REQ_INDEX: begin
            restart = (it.ival == RESTART_SHORT) || (it.ival == RESTART_LONG);
            if (restart && gathered == 0) begin
            end else if (restart || it.ival >= NVERT) begin
               gathered = 0;
               pending_normals = {pending_normals, drop};
            end else if (gathered == 0) begin
               corner_a = it.ival; gathered = 1;
            end else if (gathered == 1) begin
               corner_b = it.ival; gathered = 2;
            end else begin
               add_face(corner_a, corner_b, it.ival);
               gathered = 0;
            end
         end
         REQ_READ: pending_normals = {pending_normals, unit_normal(it.vidx)};
         default: begin
            for (int i = 0; i < NVERT; i++) begin
               sum_x[i] = '0; sum_y[i] = '0; sum_z[i] = '0;
            end
         end
      endcase
   endfunction

   // stimulus builders
   function automatic void put(input req_code_type k, input int v, input int x, input int y,
                               input int z, input logic [IVAL_W-1:0] iv, input bit d = 0);
      req_item_type it;
      it.kind = k;
      it.vidx = VIDX_W'(v);
      it.px = POS_W'(x);
      it.py = POS_W'(y);
      it.pz = POS_W'(z);
      it.ival = iv;
      it.drain = d;
      pending_reqs = {pending_reqs, it};
      if (k == REQ_LOAD && !is_written[it.vidx]) begin
         is_written[it.vidx] = 1;
         written_ids = {written_ids, int'(it.vidx)};
      end
   endfunction

   function automatic int pick_vertex();
      // favor the first few loaded so accumulators pile up
      if ($urandom_range(0, 3) != 0 && written_ids.size() > 12)
         return written_ids[$urandom_range(0, 11)];
      return written_ids[$urandom_range(0, written_ids.size() - 1)];
   endfunction

   function automatic void load_random(input int v);
      int sc;
      sc = $urandom_range(0, 2);
      if (sc == 0)
         put(REQ_LOAD, v, $urandom(), $urandom(), $urandom(), $urandom());
      else
         put(REQ_LOAD, v, $signed(24'($urandom())) >>> 8, $signed(24'($urandom())) >>> 8,
             $signed(24'($urandom())) >>> 8, $urandom());
   endfunction

   function automatic logic [IVAL_W-1:0] bad_index();
      case ($urandom_range(0, 3))
         0: return NVERT;
         1: return 32'hFFFF_FFFE;
         default: return $urandom_range(NVERT, 32'hFFFF_FFFE) ^ 32'h0;
      endcase
   endfunction

   initial begin
      int n, clears, r;
      for (int i = 0; i < NVERT; i++) begin
         sum_x[i] = '0; sum_y[i] = '0; sum_z[i] = '0;
         pos_x_mem[i] = '0; pos_y_mem[i] = '0; pos_z_mem[i] = '0;
         is_written[i] = 0;
      end
      gathered = 0; corner_a = 0; corner_b = 0;

      // directed
      put(REQ_LOAD, 0, 24'sh7FFFFF, -24'sh800000, 0, 32'hFFFF_FFFF);
      put(REQ_LOAD, 1, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 0);
      put(REQ_LOAD, 2, 0, 0, -24'sh800000, 0);
      put(REQ_LOAD, 1023, 24'sh10000, -24'sh10000, 24'sh2000, 0);
      put(REQ_INDEX, 0, 0, 0, 0, RESTART_SHORT);       // skipped at group start
      put(REQ_INDEX, 0, 0, 0, 0, 0);
      put(REQ_INDEX, 0, 0, 0, 0, 1);
      put(REQ_INDEX, 0, 0, 0, 0, 2);
      put(REQ_INDEX, 0, 0, 0, 0, 1023);
      put(REQ_INDEX, 0, 0, 0, 0, 0);
      put(REQ_INDEX, 0, 0, 0, 0, 1);
      put(REQ_READ, 0, 0, 0, 0, 0);
      put(REQ_READ, 1023, 0, 0, 0, 0);
      put(REQ_READ, 500, 0, 0, 0, 0);                   // zero vector
      put(REQ_INDEX, 0, 0, 0, 0, 2);
      put(REQ_INDEX, 0, 0, 0, 0, RESTART_LONG);         // restart mid group
      put(REQ_INDEX, 0, 0, 0, 0, NVERT);                // out of range at start
      put(REQ_INDEX, 0, 0, 0, 0, 1);
      put(REQ_INDEX, 0, 0, 0, 0, 32'hFFFF_FFFE);        // out of range mid group
      put(REQ_INDEX, 0, 0, 0, 0, 0);
      put(REQ_CLEAR, 0, 0, 0, 0, 0);                    // gathering kept across clear
      put(REQ_INDEX, 0, 0, 0, 0, 1);
      put(REQ_INDEX, 0, 0, 0, 0, 2);
      put(REQ_READ, 1, 0, 0, 0, 0);
      put(REQ_READ, 2, 0, 0, 0, 0, 1);

      for (int v = 3; v < 40; v++) load_random(v);
      clears = 1;
      n = pending_reqs.size();
      while (n < 1750) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            load_random($urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1)
                                                  : $urandom_range(0, 63));
            n += 1;
         end else if (r < 62) begin
            for (int k = 0; k < 3; k++) put(REQ_INDEX, $urandom(), 0, 0, 0, pick_vertex());
            n += 3;
         end else if (r < 82) begin
            put(REQ_READ, $urandom_range(0, 4) == 0 ? $urandom_range(0, NVERT - 1)
                                                    : pick_vertex(), 0, 0, 0, $urandom());
            n += 1;
         end else if (r < 90) begin
            // broken group ended by a restart marker
            for (int k = 0; k < $urandom_range(0, 2); k++)
               put(REQ_INDEX, 0, 0, 0, 0, pick_vertex());
            put(REQ_INDEX, 0, 0, 0, 0, $urandom_range(0, 1) ? RESTART_SHORT : RESTART_LONG);
            n += 2;
         end else if (r < 97) begin
            if ($urandom_range(0, 1)) put(REQ_INDEX, 0, 0, 0, 0, pick_vertex());
            put(REQ_INDEX, 0, 0, 0, 0, bad_index());
            n += 2;
         end else if (clears < 5) begin
            put(REQ_CLEAR, $urandom(), 0, 0, 0, 0);
            clears++;
            n += 1;
         end
         if (n > 900 && n < 905) pending_reqs[$].drain = 1;
      end
      stim_done = 1;
   end

   // request driver
   always @(posedge clock) begin
      int phase, idle_pct;
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            it.kind = req_code_type'(req_type);
            it.vidx = req_vertex_index;
            it.px = req_pos_x; it.py = req_pos_y; it.pz = req_pos_z;
            it.ival = req_index_value;
            predict_normals(it);
            accepted++;
         end
         phase = accepted < 600 ? 0 : accepted < 1200 ? 1 : 2;
         idle_pct = phase == 0 ? 18 : phase == 1 ? 64 : 0;
         if (pending_reqs.size() == 0 ||
             (pending_reqs[0].drain && (pending_normals.size() != 0 || req_valid)) ||
             $urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
         end else begin
            it = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_type <= it.kind;
            req_vertex_index <= it.vidx;
            req_pos_x <= it.px;
            req_pos_y <= it.py;
            req_pos_z <= it.pz;
            req_index_value <= it.ival;
         end
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin
      normal_rsp_type exp_n;
      int stall_pct;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: status %0d vertex %0d normal %0d %0d %0d",
                        rsp_status, rsp_normal_vertex, rsp_normal_x, rsp_normal_y,
                        rsp_normal_z);
         end else begin
            exp_n = pending_normals.pop_front();
            if (rsp_status !== exp_n.status || rsp_normal_vertex !== exp_n.vertex ||
                rsp_normal_x !== exp_n.nx || rsp_normal_y !== exp_n.ny ||
                rsp_normal_z !== exp_n.nz) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp %0d/%0d (%0d %0d %0d) got %0d/%0d (%0d %0d %0d)",
                           exp_n.status, exp_n.vertex, exp_n.nx, exp_n.ny, exp_n.nz,
                           rsp_status, rsp_normal_vertex, rsp_normal_x, rsp_normal_y,
                           rsp_normal_z);
            end
         end
      end
      // one long hold-off so the block backs up into req_stall
      if (!hold_done && accepted >= 400) begin
         hold_done <= 1;
         rx_hold <= 800;
         rsp_stall <= 1'b1;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_pct = accepted < 600 ? 64 : accepted < 1200 ? 18 : 0;
         rsp_stall <= $urandom_range(0, 99) < stall_pct;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!stim_done || pending_reqs.size() != 0 || req_valid ||
             pending_normals.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0 && pending_normals.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
